[rtl/stt_pkg.sv]
// Shared types, codes and sizes for the script text tokenizer.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package stt_pkg;

   localparam int LINE_BITS    = 24;
   localparam int TOKEN_LINE_W = 24;

   localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};
   localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);
   localparam logic [RSP_PTR_W-1:0] RSP_PTR_ONE  = {{(RSP_PTR_W-1){1'b0}}, 1'b1};
   localparam logic [RSP_CNT_W-1:0] RSP_ROOM_MAX = RSP_CNT_W'(RSP_DEPTH - 2);

   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [2:0] TOK_WORD    = 3'd0;
   localparam logic [2:0] TOK_QUOTE   = 3'd1;
   localparam logic [2:0] TOK_VAR     = 3'd2;
   localparam logic [2:0] TOK_NEWLINE = 3'd3;
   localparam logic [2:0] TOK_LBRACE  = 3'd4;
   localparam logic [2:0] TOK_RBRACE  = 3'd5;
   localparam logic [2:0] TOK_COLON   = 3'd6;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef enum logic [2:0] {
      MODE_READY    = 3'd0,
      MODE_LCOMMENT = 3'd1,
      MODE_BCOMMENT = 3'd2,
      MODE_WORD     = 3'd3,
      MODE_QUOTE    = 3'd4,
      MODE_VAR      = 3'd5,
      MODE_POSSIBLE = 3'd6
   } lex_mode_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_byte;
   } req_payload_type;

   typedef struct packed {
      logic                    has_char;
      logic [7:0]              out_char;
      logic                    token_end;
      logic [2:0]              token_type;
      logic [TOKEN_LINE_W-1:0] token_line;
      logic                    error;
      logic                    last;
   } rsp_payload_type;

   typedef struct packed {
      lex_mode_type         mode;
      logic [7:0]           prev_char;
      logic [LINE_BITS-1:0] line_count;
      logic [7:0]           first_char;
      logic [1:0]           tok_len;
      logic                 last_nl;
   } lex_state_type;

   localparam lex_state_type LEX_RESET = '{
      mode:       MODE_READY,
      prev_char:  8'h00,
      line_count: LINE_ONE,
      first_char: 8'h00,
      tok_len:    2'd0,
      last_nl:    1'b0
   };

   // results of one request, handed from the lexer to the result queue
   typedef struct packed {
      logic [1:0]      cnt;
      rsp_payload_type r0;
      rsp_payload_type r1;
   } lex_out_type;

endpackage

[rtl/stt_lex_core.sv]
// Lexer state registers and the single-pass next-state / result logic.
// Depends on stt_pkg.
module stt_lex_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  stt_pkg::req_payload_type item,
   output stt_pkg::lex_out_type    lex_out
);

   typedef struct packed {
      stt_pkg::lex_state_type st;
      stt_pkg::lex_out_type   o;
   } step_type;

   stt_pkg::lex_state_type state_ff;
   step_type               s;
   logic [7:0]             c;
   logic [7:0]             lc;

   function automatic logic is_nl(logic [7:0] ch);
      return (ch == stt_pkg::CH_LF) || (ch == stt_pkg::CH_CR);
   endfunction

   function automatic logic is_ws(logic [7:0] ch);
      return (ch == stt_pkg::CH_SPACE) || (ch == stt_pkg::CH_CR) || (ch == stt_pkg::CH_TAB);
   endfunction

   function automatic logic is_sep(logic [7:0] ch);
      return (ch == stt_pkg::CH_LBRACE) || (ch == stt_pkg::CH_RBRACE) ||
             (ch == stt_pkg::CH_COLON);
   endfunction

   function automatic logic [stt_pkg::TOKEN_LINE_W-1:0] line_out(
      logic [stt_pkg::LINE_BITS-1:0] line
   );
      logic [31:0] wide;
      wide = 32'(line);
      return wide[stt_pkg::TOKEN_LINE_W-1:0];
   endfunction

   // Append one result: add the character, then close the token if asked.
   function automatic step_type put_fn(step_type s_in, logic hc, logic [7:0] ch,
                                       logic end_t, logic err);
      step_type                 sx;
      stt_pkg::rsp_payload_type r;
      logic [2:0]               t;
      logic [7:0]               f;
      logic                     one;
      sx = s_in;
      t  = stt_pkg::TOK_WORD;
      if (hc) begin
         if (sx.st.tok_len == 2'd0) sx.st.first_char = ch;
         if (sx.st.tok_len < 2'd2) sx.st.tok_len = sx.st.tok_len + 2'd1;
      end
      if (end_t) begin
         f   = sx.st.first_char;
         one = (sx.st.tok_len == 2'd1);
         priority if (one && is_nl(f))                  t = stt_pkg::TOK_NEWLINE;
         else if (one && f == stt_pkg::CH_LBRACE)       t = stt_pkg::TOK_LBRACE;
         else if (one && f == stt_pkg::CH_RBRACE)       t = stt_pkg::TOK_RBRACE;
         else if (one && f == stt_pkg::CH_COLON)        t = stt_pkg::TOK_COLON;
         else if (f == stt_pkg::CH_DOLLAR)              t = stt_pkg::TOK_VAR;
         else if (sx.st.tok_len >= 2'd2 && f == stt_pkg::CH_DQUOTE) t = stt_pkg::TOK_QUOTE;
         else                                           t = stt_pkg::TOK_WORD;
         sx.st.tok_len    = 2'd0;
         sx.st.first_char = 8'h00;
         sx.st.last_nl    = (t == stt_pkg::TOK_NEWLINE);
      end
      r.has_char   = hc;
      r.out_char   = hc ? ch : 8'h00;
      r.token_end  = end_t;
      r.token_type = t;
      r.token_line = line_out(sx.st.line_count);
      r.error      = err;
      r.last       = 1'b0;
      if (sx.o.cnt == 2'd0) sx.o.r0 = r;
      else                  sx.o.r1 = r;
      sx.o.cnt = sx.o.cnt + 2'd1;
      return sx;
   endfunction

   // Drop a newline token that directly follows another one.
   function automatic step_type put_newline(step_type s_in, logic [7:0] ch);
      step_type sx;
      sx = s_in;
      if (!sx.st.last_nl) sx = put_fn(sx, 1'b1, ch, 1'b1, 1'b0);
      return sx;
   endfunction

   function automatic step_type word_fn(step_type s_in, logic [7:0] ch);
      step_type sx;
      sx = s_in;
      if (is_nl(ch)) begin
         sx = put_fn(sx, 1'b0, 8'h00, 1'b1, 1'b0);
         sx = put_newline(sx, ch);
         sx.st.mode = stt_pkg::MODE_READY;
      end else if (is_ws(ch)) begin
         sx = put_fn(sx, 1'b0, 8'h00, 1'b1, 1'b0);
         sx.st.mode = stt_pkg::MODE_READY;
      end else if (is_sep(ch)) begin
         sx = put_fn(sx, 1'b0, 8'h00, 1'b1, 1'b0);
         sx = put_fn(sx, 1'b1, ch, 1'b1, 1'b0);
         sx.st.mode = stt_pkg::MODE_READY;
      end else begin
         sx = put_fn(sx, 1'b1, ch, 1'b0, 1'b0);
      end
      return sx;
   endfunction

   always_comb begin
      s.st = state_ff;
      s.o  = '0;
      c    = item.char_byte;
      lc   = state_ff.prev_char;
      if (item.kind == stt_pkg::KIND_END) begin
         if (state_ff.mode == stt_pkg::MODE_WORD || state_ff.mode == stt_pkg::MODE_VAR) begin
            s = put_fn(s, 1'b0, 8'h00, 1'b1, 1'b0);
         end else if (state_ff.mode == stt_pkg::MODE_QUOTE) begin
            s = put_fn(s, 1'b0, 8'h00, 1'b0, 1'b1);
         end
         s.st = stt_pkg::LEX_RESET;
      end else begin
         unique case (state_ff.mode)
            stt_pkg::MODE_LCOMMENT: begin
               if (is_nl(c)) s.st.mode = stt_pkg::MODE_READY;
            end
            stt_pkg::MODE_BCOMMENT: begin
               if (c == stt_pkg::CH_SLASH && lc == stt_pkg::CH_STAR)
                  s.st.mode = stt_pkg::MODE_READY;
            end
            stt_pkg::MODE_POSSIBLE: begin
               if (c == stt_pkg::CH_SLASH && lc == stt_pkg::CH_SLASH) begin
                  s.st.tok_len = 2'd0;
                  s.st.mode    = stt_pkg::MODE_LCOMMENT;
               end else if (c == stt_pkg::CH_STAR && lc == stt_pkg::CH_SLASH) begin
                  s.st.tok_len = 2'd0;
                  s.st.mode    = stt_pkg::MODE_BCOMMENT;
               end else if (is_nl(c) || is_ws(c) || is_sep(c)) begin
                  s = put_fn(s, 1'b1, stt_pkg::CH_SLASH, 1'b1, 1'b0);
                  if (is_nl(c))       s = put_newline(s, c);
                  else if (is_sep(c)) s = put_fn(s, 1'b1, c, 1'b1, 1'b0);
                  s.st.mode = stt_pkg::MODE_READY;
               end else begin
                  s = put_fn(s, 1'b1, stt_pkg::CH_SLASH, 1'b0, 1'b0);
                  s = put_fn(s, 1'b1, c, 1'b0, 1'b0);
                  s.st.mode = stt_pkg::MODE_WORD;
               end
            end
            stt_pkg::MODE_WORD, stt_pkg::MODE_VAR: begin
               s = word_fn(s, c);
            end
            stt_pkg::MODE_QUOTE: begin
               if (c != stt_pkg::CH_BSLASH) begin
                  if (c == stt_pkg::CH_DQUOTE && lc == stt_pkg::CH_BSLASH) begin
                     s = put_fn(s, 1'b1, c, 1'b0, 1'b0);
                  end else if (c == stt_pkg::CH_DQUOTE) begin
                     s = put_fn(s, 1'b1, c, 1'b1, 1'b0);
                     s.st.mode = stt_pkg::MODE_READY;
                  end else if (lc == stt_pkg::CH_BSLASH) begin
                     s = put_fn(s, 1'b1, stt_pkg::CH_BSLASH, 1'b0, 1'b0);
                     s = put_fn(s, 1'b1, c, 1'b0, 1'b0);
                  end else begin
                     s = put_fn(s, 1'b1, c, 1'b0, 1'b0);
                  end
               end
            end
            default: begin
               // ready, and any unused code
               if ((c == stt_pkg::CH_SLASH || c == stt_pkg::CH_STAR) &&
                   lc == stt_pkg::CH_SLASH) begin
                  s.st.tok_len = 2'd0;
                  s.st.mode    = (c == stt_pkg::CH_SLASH) ? stt_pkg::MODE_LCOMMENT
                                                          : stt_pkg::MODE_BCOMMENT;
               end else if (c == stt_pkg::CH_DQUOTE) begin
                  s.st.tok_len = 2'd0;
                  s = put_fn(s, 1'b1, c, 1'b0, 1'b0);
                  s.st.mode = stt_pkg::MODE_QUOTE;
               end else if (c == stt_pkg::CH_DOLLAR) begin
                  s.st.tok_len = 2'd0;
                  s = put_fn(s, 1'b1, c, 1'b0, 1'b0);
                  s.st.mode = stt_pkg::MODE_VAR;
               end else if (is_nl(c)) begin
                  s.st.tok_len = 2'd0;
                  s = put_newline(s, c);
               end else if (!is_ws(c)) begin
                  s.st.tok_len = 2'd0;
                  if (c == stt_pkg::CH_SLASH) begin
                     s.st.mode = stt_pkg::MODE_POSSIBLE;
                  end else begin
                     s = put_fn(s, 1'b1, c, 1'b0, 1'b0);
                     s.st.mode = stt_pkg::MODE_WORD;
                  end
               end
            end
         endcase
         // count CR, and LF not after CR; hold at the maximum
         if (c == stt_pkg::CH_CR || (c == stt_pkg::CH_LF && lc != stt_pkg::CH_CR)) begin
            if (s.st.line_count != stt_pkg::LINE_MAX)
               s.st.line_count = s.st.line_count + stt_pkg::LINE_ONE;
         end
         s.st.prev_char = c;
      end
      // mark the final result of this request
      if (s.o.cnt == 2'd1) s.o.r0.last = 1'b1;
      if (s.o.cnt == 2'd2) s.o.r1.last = 1'b1;
   end

   // hand results out only for the request that advances the lexer
   assign lex_out = take ? s.o : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stt_pkg::LEX_RESET;
      end else if (take) begin
         state_ff <= s.st;
      end
   end

endmodule

[rtl/stt_rsp_fifo.sv]
// Small result queue: takes up to two results per cycle, hands out one.
// Depends on stt_pkg.
module stt_rsp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  stt_pkg::lex_out_type     push,
   input  logic                     pop,
   output logic                     not_empty,
   output logic                     room,
   output stt_pkg::rsp_payload_type head_data
);

   stt_pkg::rsp_payload_type        mem_ff [stt_pkg::RSP_DEPTH];
   logic [stt_pkg::RSP_PTR_W-1:0]   head_ff, head_in;
   logic [stt_pkg::RSP_PTR_W-1:0]   tail_ff, tail_in;
   logic [stt_pkg::RSP_CNT_W-1:0]   count_ff, count_in;
   logic [stt_pkg::RSP_CNT_W-1:0]   push_ext, pop_ext;
   logic [stt_pkg::RSP_PTR_W-1:0]   push_ptr;

   always_comb begin
      push_ext      = '0;
      push_ext[1:0] = push.cnt;
      pop_ext       = '0;
      pop_ext[0]    = pop;
      push_ptr      = '0;
      push_ptr[1:0] = push.cnt;
      count_in      = count_ff + push_ext - pop_ext;
      tail_in       = tail_ff + push_ptr;
      head_in       = pop ? head_ff + stt_pkg::RSP_PTR_ONE : head_ff;
   end

   assign not_empty = (count_ff != '0);
   assign room      = (count_ff <= stt_pkg::RSP_ROOM_MAX);
   assign head_data = mem_ff[head_ff];

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) mem_ff[tail_ff] <= push.r0;
      if (push.cnt == 2'd2) mem_ff[tail_ff + stt_pkg::RSP_PTR_ONE] <= push.r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/script_text_tokenizer.sv]
// Top level of the script text tokenizer: request register, lexer core, result queue.
// Depends on stt_pkg, stt_lex_core and stt_rsp_fifo.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   stt_pkg::req_payload_type (kind, char_byte)
//   rsp_      out        rsp_valid/rsp_ready   stt_pkg::rsp_payload_type (one result)
//
// A request is accepted in any cycle where the request register is empty or
// drains that cycle; it drains into the lexer when the result queue holds at
// most two results. Each request gives zero, one or two results, handed out one
// per cycle while rsp_ready is high, so the sustained rate is one request per
// cycle when the rsp port keeps up and no request gives two results.
// A request's results pass the request register and the result queue before
// they show on rsp; a full queue holds the request in its register.
// Synchronous reset empties the request register and the queue and puts the
// lexer in ready mode at line one. A low rsp_ready holds the queue head;
// req_ready drops once the queue fills past two results.
module script_text_tokenizer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  stt_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output stt_pkg::rsp_payload_type rsp_payload
);

   logic                     in_valid_ff, in_valid_in;
   stt_pkg::req_payload_type in_item_ff;
   logic                     take;
   logic                     room;
   logic                     req_fire;
   logic                     rsp_fire;
   stt_pkg::lex_out_type     lex_out;

   // hand the held request to the lexer whenever the queue can absorb two results
   assign take      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || take;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   always_comb begin
      priority if (req_fire) in_valid_in = 1'b1;
      else if (take)         in_valid_in = 1'b0;
      else                   in_valid_in = in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload register: load on accept, no reset
   always_ff @(posedge clock) begin
      if (req_fire) in_item_ff <= req_payload;
   end

   stt_lex_core u_lex_core (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .item    (in_item_ff),
      .lex_out (lex_out)
   );

   stt_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (lex_out),
      .pop       (rsp_fire),
      .not_empty (rsp_valid),
      .room      (room),
      .head_data (rsp_payload)
   );

   // the final result of every request group carries last, and only that one
   a_last_marks_group: assert property (@(posedge clock) disable iff (reset)
      (take && lex_out.cnt != 2'd0) |->
         ((lex_out.cnt == 2'd1 && lex_out.r0.last) ||
          (lex_out.cnt == 2'd2 && lex_out.r1.last && !lex_out.r0.last)))
      else $error("last flag misplaced in result group");

   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.error) |->
         (!rsp_payload.token_end && !rsp_payload.has_char && rsp_payload.last))
      else $error("error result carries other content");

   a_type_needs_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.token_end) |-> (rsp_payload.token_type == stt_pkg::TOK_WORD))
      else $error("token type given without token end");

   a_valid_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(take && lex_out.cnt != 2'd0))
      else $error("result appeared without a lexer push");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for script_text_tokenizer: directed table, then random script text.
// Depends on stt_pkg and the script_text_tokenizer RTL; the byte lexer is predicted in place.
module tb_top;

   typedef struct {
      stt_pkg::req_payload_type req;
      int                       cnt;   // -1: take expectations from the predictor
      stt_pkg::rsp_payload_type exp0;
      stt_pkg::rsp_payload_type exp1;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   stt_pkg::req_payload_type req_payload;
   logic                     rsp_valid;
   logic                     rsp_ready;
   stt_pkg::rsp_payload_type rsp_payload;

   // lexer state mirrored by the predictor
   stt_pkg::lex_state_type   lx;
   stt_pkg::rsp_payload_type step_rsp [2];
   int                       step_cnt;

   stt_pkg::rsp_payload_type expected_rsp [$];
   stim_row_type             directed_rows [$];
   stt_pkg::req_payload_type text_q [$];

   // typed expectation that rides along with the request on the bus
   int                       cur_cnt;
   stt_pkg::rsp_payload_type cur_exp0;
   stt_pkg::rsp_payload_type cur_exp1;

   int                       mismatch_count = 0;
   int                       rsp_index = 0;
   bit                       send_idle_en = 1'b1;
   bit                       rsp_stall_en = 1'b1;

   script_text_tokenizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Byte classes
   // ---------------------------------------------------------------------
   function automatic bit is_line_break(input logic [7:0] c);
      return c == stt_pkg::CH_LF || c == stt_pkg::CH_CR;
   endfunction

   // CR counts as blank too; callers test line breaks first
   function automatic bit is_blank(input logic [7:0] c);
      return c == stt_pkg::CH_SPACE || c == stt_pkg::CH_CR || c == stt_pkg::CH_TAB;
   endfunction

   function automatic bit is_separator(input logic [7:0] c);
      return c == stt_pkg::CH_LBRACE || c == stt_pkg::CH_RBRACE || c == stt_pkg::CH_COLON;
   endfunction

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   // Work out the token type from the first character and the length, then
   // clear the open token.
   function automatic logic [2:0] close_token();
      logic [2:0] ty;
      ty = stt_pkg::TOK_WORD;
      if (lx.tok_len == 2'd1 && is_line_break(lx.first_char))
         ty = stt_pkg::TOK_NEWLINE;
      else if (lx.tok_len == 2'd1 && lx.first_char == stt_pkg::CH_LBRACE)
         ty = stt_pkg::TOK_LBRACE;
      else if (lx.tok_len == 2'd1 && lx.first_char == stt_pkg::CH_RBRACE)
         ty = stt_pkg::TOK_RBRACE;
      else if (lx.tok_len == 2'd1 && lx.first_char == stt_pkg::CH_COLON)
         ty = stt_pkg::TOK_COLON;
      else if (lx.first_char == stt_pkg::CH_DOLLAR)
         ty = stt_pkg::TOK_VAR;
      else if (lx.tok_len == 2'd2 && lx.first_char == stt_pkg::CH_DQUOTE)
         ty = stt_pkg::TOK_QUOTE;
      lx.tok_len    = 2'd0;
      lx.first_char = 8'h00;
      lx.last_nl    = (ty == stt_pkg::TOK_NEWLINE);
      return ty;
   endfunction

   // Append one result of the current request; the line is the count before
   // this byte's own line step.
   function automatic void emit(input logic hc, input logic [7:0] ch,
                                input logic closes, input logic err);
      stt_pkg::rsp_payload_type r;
      r = '0;
      if (hc) begin
         if (lx.tok_len == 2'd0) lx.first_char = ch;
         if (lx.tok_len != 2'd2) lx.tok_len = lx.tok_len + 2'd1;
      end
      r.has_char   = hc;
      r.out_char   = hc ? ch : 8'h00;
      r.token_end  = closes;
      r.token_type = closes ? close_token() : stt_pkg::TOK_WORD;
      r.token_line = stt_pkg::TOKEN_LINE_W'(lx.line_count);
      r.error      = err;
      step_rsp[step_cnt] = r;
      step_cnt++;
   endfunction

   // Drop a newline token that follows another one.
   function automatic void emit_newline(input logic [7:0] c);
      if (!lx.last_nl) emit(1'b1, c, 1'b1, 1'b0);
   endfunction

   function automatic void word_byte(input logic [7:0] c);
      if (is_line_break(c)) begin
         emit(1'b0, 8'h00, 1'b1, 1'b0);
         emit_newline(c);
         lx.mode = stt_pkg::MODE_READY;
      end else if (is_blank(c)) begin
         emit(1'b0, 8'h00, 1'b1, 1'b0);
         lx.mode = stt_pkg::MODE_READY;
      end else if (is_separator(c)) begin
         emit(1'b0, 8'h00, 1'b1, 1'b0);
         emit(1'b1, c, 1'b1, 1'b0);
         lx.mode = stt_pkg::MODE_READY;
      end else begin
         emit(1'b1, c, 1'b0, 1'b0);
      end
   endfunction

   // Advance the mirrored lexer by one request and collect what it yields.
   function automatic void lex_step(input stt_pkg::req_payload_type p);
      logic [7:0] c;
      logic [7:0] lc;
      c        = p.char_byte;
      lc       = lx.prev_char;
      step_cnt = 0;
      if (p.kind == stt_pkg::KIND_END) begin
         // flush an open word or variable, flag an open quote, drop the rest
         if (lx.mode == stt_pkg::MODE_WORD || lx.mode == stt_pkg::MODE_VAR)
            emit(1'b0, 8'h00, 1'b1, 1'b0);
         else if (lx.mode == stt_pkg::MODE_QUOTE)
            emit(1'b0, 8'h00, 1'b0, 1'b1);
         lx = stt_pkg::LEX_RESET;
      end else begin
         case (lx.mode)
            stt_pkg::MODE_LCOMMENT: begin
               if (is_line_break(c)) lx.mode = stt_pkg::MODE_READY;
            end
            stt_pkg::MODE_BCOMMENT: begin
               if (c == stt_pkg::CH_SLASH && lc == stt_pkg::CH_STAR)
                  lx.mode = stt_pkg::MODE_READY;
            end
            stt_pkg::MODE_POSSIBLE: begin
               if (c == stt_pkg::CH_SLASH && lc == stt_pkg::CH_SLASH) begin
                  lx.tok_len = 2'd0;
                  lx.mode    = stt_pkg::MODE_LCOMMENT;
               end else if (c == stt_pkg::CH_STAR && lc == stt_pkg::CH_SLASH) begin
                  lx.tok_len = 2'd0;
                  lx.mode    = stt_pkg::MODE_BCOMMENT;
               end else begin
                  // release the held slash; a delimiter closes it in the same result
                  emit(1'b1, stt_pkg::CH_SLASH, 1'b0, 1'b0);
                  lx.mode = stt_pkg::MODE_WORD;
                  if (is_line_break(c) || is_blank(c) || is_separator(c)) begin
                     step_rsp[0].token_end  = 1'b1;
                     step_rsp[0].token_type = close_token();
                     if (is_line_break(c)) emit_newline(c);
                     else if (is_separator(c)) emit(1'b1, c, 1'b1, 1'b0);
                     lx.mode = stt_pkg::MODE_READY;
                  end else begin
                     emit(1'b1, c, 1'b0, 1'b0);
                  end
               end
            end
            stt_pkg::MODE_WORD, stt_pkg::MODE_VAR: word_byte(c);
            stt_pkg::MODE_QUOTE: begin
               // a backslash shows nothing until the next byte decides
               if (c != stt_pkg::CH_BSLASH) begin
                  if (c == stt_pkg::CH_DQUOTE && lc == stt_pkg::CH_BSLASH) begin
                     emit(1'b1, c, 1'b0, 1'b0);
                  end else if (c == stt_pkg::CH_DQUOTE) begin
                     emit(1'b1, c, 1'b1, 1'b0);
                     lx.mode = stt_pkg::MODE_READY;
                  end else if (lc == stt_pkg::CH_BSLASH) begin
                     emit(1'b1, stt_pkg::CH_BSLASH, 1'b0, 1'b0);
                     emit(1'b1, c, 1'b0, 1'b0);
                  end else begin
                     emit(1'b1, c, 1'b0, 1'b0);
                  end
               end
            end
            default: begin
               if ((c == stt_pkg::CH_SLASH || c == stt_pkg::CH_STAR) &&
                   lc == stt_pkg::CH_SLASH) begin
                  lx.tok_len = 2'd0;
                  lx.mode    = (c == stt_pkg::CH_SLASH) ? stt_pkg::MODE_LCOMMENT
                                                        : stt_pkg::MODE_BCOMMENT;
               end else if (c == stt_pkg::CH_DQUOTE) begin
                  lx.tok_len = 2'd0;
                  emit(1'b1, c, 1'b0, 1'b0);
                  lx.mode = stt_pkg::MODE_QUOTE;
               end else if (c == stt_pkg::CH_DOLLAR) begin
                  lx.tok_len = 2'd0;
                  emit(1'b1, c, 1'b0, 1'b0);
                  lx.mode = stt_pkg::MODE_VAR;
               end else if (is_line_break(c)) begin
                  lx.tok_len = 2'd0;
                  emit_newline(c);
               end else if (!is_blank(c)) begin
                  lx.tok_len = 2'd0;
                  if (c == stt_pkg::CH_SLASH) begin
                     lx.mode = stt_pkg::MODE_POSSIBLE;
                  end else begin
                     emit(1'b1, c, 1'b0, 1'b0);
                     lx.mode = stt_pkg::MODE_WORD;
                  end
               end
            end
         endcase
         // count CR, and LF not right after CR; hold at the top value
         if (c == stt_pkg::CH_CR || (c == stt_pkg::CH_LF && lc != stt_pkg::CH_CR)) begin
            if (lx.line_count != stt_pkg::LINE_MAX)
               lx.line_count = lx.line_count + stt_pkg::LINE_ONE;
         end
         lx.prev_char = c;
      end
      if (step_cnt > 0) step_rsp[step_cnt-1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic note_mismatch(input string msg);
      $display("MISMATCH t=%0t result %0d: %s", $time, rsp_index, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         note_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
   endtask

   // Sample both channels at the rising edge: predict each accepted request,
   // then compare each accepted result against the oldest expectation.
   always @(posedge clock) begin : monitor
      stt_pkg::rsp_payload_type want;
      if (reset) begin
         lx = stt_pkg::LEX_RESET;
      end else begin
         if (req_valid && req_ready) begin
            lex_step(req_payload);
            if (cur_cnt < 0) begin
               for (int i = 0; i < step_cnt; i++)
                  expected_rsp.insert(expected_rsp.size(), step_rsp[i]);
            end else begin
               if (cur_cnt > 0) expected_rsp.insert(expected_rsp.size(), cur_exp0);
               if (cur_cnt > 1) expected_rsp.insert(expected_rsp.size(), cur_exp1);
            end
         end
         if (rsp_valid && rsp_ready) begin
            rsp_index++;
            if (expected_rsp.size() == 0) begin
               note_mismatch("result with nothing pending");
            end else begin
               want = expected_rsp.pop_front();
               check_field("has_char", 32'(rsp_payload.has_char), 32'(want.has_char));
               check_field("out_char", 32'(rsp_payload.out_char), 32'(want.out_char));
               check_field("token_end", 32'(rsp_payload.token_end), 32'(want.token_end));
               check_field("token_type", 32'(rsp_payload.token_type),
                           32'(want.token_type));
               check_field("token_line", 32'(rsp_payload.token_line),
                           32'(want.token_line));
               check_field("error", 32'(rsp_payload.error), 32'(want.error));
               check_field("last", 32'(rsp_payload.last), 32'(want.last));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Drive one request at the falling edge after a random gap, then hold it
   // until accepted. Returns at the falling edge after acceptance with valid
   // still high, so a back-to-back request just swaps the payload.
   task automatic send_req(input stt_pkg::req_payload_type p, input int cnt,
                           input stt_pkg::rsp_payload_type r0,
                           input stt_pkg::rsp_payload_type r1);
      int gap;
      if ($urandom_range(0, 63) == 0) send_idle_en = !send_idle_en;
      gap = send_idle_en ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      cur_cnt     = cnt;
      cur_exp0    = r0;
      cur_exp1    = r1;
      req_payload = p;
      req_valid   = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid and hold off until every pending result has come back.
   task automatic drain_results();
      req_valid = 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
   endtask

   function automatic stt_pkg::rsp_payload_type mk_rsp(input logic hc, input logic [7:0] ch,
                                                       input logic closes,
                                                       input logic [2:0] ty,
                                                       input logic err, input logic fin);
      stt_pkg::rsp_payload_type r;
      r.has_char   = hc;
      r.out_char   = ch;
      r.token_end  = closes;
      r.token_type = ty;
      r.token_line = stt_pkg::TOKEN_LINE_W'(stt_pkg::LINE_ONE);   // typed rows sit on line one
      r.error      = err;
      r.last       = fin;
      return r;
   endfunction

   task automatic add_row(input logic kind, input logic [7:0] ch, input int cnt,
                          input stt_pkg::rsp_payload_type r0,
                          input stt_pkg::rsp_payload_type r1);
      stim_row_type row;
      row.req.kind      = kind;
      row.req.char_byte = ch;
      row.cnt           = cnt;
      row.exp0          = r0;
      row.exp1          = r1;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic push_text(input logic [7:0] c);
      stt_pkg::req_payload_type p;
      p.kind      = stt_pkg::KIND_TEXT;
      p.char_byte = c;
      text_q.insert(text_q.size(), p);
   endtask

   // Byte that keeps a word going; a lead byte must also open a plain word.
   function automatic logic [7:0] plain_byte(input bit lead);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (is_line_break(c) || is_blank(c) || is_separator(c) ||
             (lead && (c == stt_pkg::CH_DQUOTE || c == stt_pkg::CH_DOLLAR ||
                       c == stt_pkg::CH_SLASH)));
      return c;
   endfunction

   // Append one well-formed piece of script text, or some noise.
   task automatic gen_fragment();
      int pick;
      int sel;
      int n;
      logic [7:0] c;
      stt_pkg::req_payload_type p;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         push_text(plain_byte(1'b1));
         n = $urandom_range(0, 5);
         repeat (n) push_text(plain_byte(1'b0));
      end else if (pick < 28) begin
         push_text(stt_pkg::CH_DOLLAR);
         n = $urandom_range(0, 4);
         repeat (n) push_text(plain_byte(1'b0));
      end else if (pick < 40) begin
         // quote with escapes; sometimes left open
         push_text(stt_pkg::CH_DQUOTE);
         n = $urandom_range(0, 6);
         repeat (n) begin
            sel = $urandom_range(0, 5);
            case (sel)
               0: begin push_text(stt_pkg::CH_BSLASH); push_text(stt_pkg::CH_DQUOTE); end
               1: begin push_text(stt_pkg::CH_BSLASH); push_text(plain_byte(1'b0)); end
               2: begin push_text(stt_pkg::CH_BSLASH); push_text(stt_pkg::CH_BSLASH); end
               default: begin
                  c = 8'($urandom_range(0, 255));
                  if (c == stt_pkg::CH_DQUOTE || c == stt_pkg::CH_BSLASH) c = 8'h61;
                  push_text(c);
               end
            endcase
         end
         if ($urandom_range(0, 9) != 0) push_text(stt_pkg::CH_DQUOTE);
      end else if (pick < 50) begin
         sel = $urandom_range(0, 2);
         push_text(sel == 0 ? stt_pkg::CH_LBRACE
                            : (sel == 1 ? stt_pkg::CH_RBRACE : stt_pkg::CH_COLON));
      end else if (pick < 60) begin
         n = $urandom_range(1, 3);
         repeat (n) push_text($urandom_range(0, 1) ? stt_pkg::CH_SPACE : stt_pkg::CH_TAB);
      end else if (pick < 70) begin
         sel = $urandom_range(0, 3);
         case (sel)
            0: push_text(stt_pkg::CH_CR);
            1: push_text(stt_pkg::CH_LF);
            2: begin push_text(stt_pkg::CH_CR); push_text(stt_pkg::CH_LF); end
            default: begin push_text(stt_pkg::CH_LF); push_text(stt_pkg::CH_LF); end
         endcase
      end else if (pick < 76) begin
         push_text(stt_pkg::CH_SLASH);
         push_text(stt_pkg::CH_SLASH);
         n = $urandom_range(0, 5);
         repeat (n) begin
            do c = 8'($urandom_range(0, 255)); while (is_line_break(c));
            push_text(c);
         end
         push_text($urandom_range(0, 1) ? stt_pkg::CH_LF : stt_pkg::CH_CR);
      end else if (pick < 83) begin
         // block comment, sometimes closed by the star that opened it
         push_text(stt_pkg::CH_SLASH);
         push_text(stt_pkg::CH_STAR);
         if ($urandom_range(0, 3) != 0) begin
            n = $urandom_range(0, 5);
            repeat (n) push_text(8'($urandom_range(0, 255)));
            push_text(stt_pkg::CH_STAR);
         end
         push_text(stt_pkg::CH_SLASH);
      end else if (pick < 90) begin
         // lone slash followed by whatever decides it
         push_text(stt_pkg::CH_SLASH);
         sel = $urandom_range(0, 5);
         case (sel)
            0: push_text(plain_byte(1'b0));
            1: push_text(stt_pkg::CH_LBRACE);
            2: push_text(stt_pkg::CH_SPACE);
            3: push_text($urandom_range(0, 1) ? stt_pkg::CH_LF : stt_pkg::CH_CR);
            4: push_text(stt_pkg::CH_DQUOTE);
            default: push_text(stt_pkg::CH_DOLLAR);
         endcase
      end else if (pick < 97) begin
         n = $urandom_range(1, 4);
         repeat (n) push_text(8'($urandom_range(0, 255)));
      end else begin
         p.kind      = stt_pkg::KIND_END;
         p.char_byte = 8'($urandom_range(0, 255));
         text_q.insert(text_q.size(), p);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: stall a random number of cycles before taking each result,
   // with stretches of no stall at all.
   // ---------------------------------------------------------------------
   initial begin : rsp_sink
      int stall;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 63) == 0) rsp_stall_en = !rsp_stall_en;
         stall = rsp_stall_en ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      cur_cnt     = -1;
      cur_exp0    = '0;
      cur_exp1    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // words, byte extremes, a separator and a newline pair
      add_row(stt_pkg::KIND_TEXT, 8'h61, 1,
              mk_rsp(1'b1, 8'h61, 1'b0, stt_pkg::TOK_WORD, 1'b0, 1'b1), '0);
      add_row(stt_pkg::KIND_TEXT, 8'hFF, 1,
              mk_rsp(1'b1, 8'hFF, 1'b0, stt_pkg::TOK_WORD, 1'b0, 1'b1), '0);
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_SPACE, 1,
              mk_rsp(1'b0, 8'h00, 1'b1, stt_pkg::TOK_WORD, 1'b0, 1'b1), '0);
      add_row(stt_pkg::KIND_TEXT, 8'h00, 1,
              mk_rsp(1'b1, 8'h00, 1'b0, stt_pkg::TOK_WORD, 1'b0, 1'b1), '0);
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_LBRACE, 2,
              mk_rsp(1'b0, 8'h00, 1'b1, stt_pkg::TOK_WORD, 1'b0, 1'b0),
              mk_rsp(1'b1, stt_pkg::CH_LBRACE, 1'b1, stt_pkg::TOK_LBRACE, 1'b0, 1'b1));
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_CR, 1,
              mk_rsp(1'b1, stt_pkg::CH_CR, 1'b1, stt_pkg::TOK_NEWLINE, 1'b0, 1'b1), '0);
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_LF, 0, '0, '0);   // repeated newline
      // variable flushed by end of text
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_DOLLAR, -1, '0, '0);
      add_row(stt_pkg::KIND_END, 8'hFF, -1, '0, '0);
      // quote with escaped quote and escaped letter, left open at end of text
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_DQUOTE, -1, '0, '0);
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_BSLASH, -1, '0, '0);
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_DQUOTE, -1, '0, '0);
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_BSLASH, -1, '0, '0);
      add_row(stt_pkg::KIND_TEXT, 8'h6E, -1, '0, '0);
      add_row(stt_pkg::KIND_END, 8'hFF, 1,
              mk_rsp(1'b0, 8'h00, 1'b0, stt_pkg::TOK_WORD, 1'b1, 1'b1), '0);
      // block comment closed by its own star, a second one right after, then
      // a line comment opened by the closing slash
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_SLASH, -1, '0, '0);
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_STAR, -1, '0, '0);
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_SLASH, -1, '0, '0);
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_STAR, -1, '0, '0);
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_SLASH, -1, '0, '0);
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_SLASH, -1, '0, '0);
      add_row(stt_pkg::KIND_TEXT, 8'h77, -1, '0, '0);
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_LF, -1, '0, '0);
      // held slash dropped by end of text
      add_row(stt_pkg::KIND_TEXT, stt_pkg::CH_SLASH, -1, '0, '0);
      add_row(stt_pkg::KIND_END, 8'h00, -1, '0, '0);

      foreach (directed_rows[i])
         send_req(directed_rows[i].req, directed_rows[i].cnt,
                  directed_rows[i].exp0, directed_rows[i].exp1);
      drain_results();

      while (text_q.size() < 1050) gen_fragment();
      foreach (text_q[i]) begin
         if (i == text_q.size() / 2) drain_results();
         send_req(text_q[i], -1, '0, '0);
      end
      drain_results();

      // let any late result show up before judging
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("script_text_tokenizer verification clean");
      end else begin
         $display("script_text_tokenizer verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("script_text_tokenizer verification failed");
      $finish;
   end

endmodule
